### src/ffl_alloc_pkg.sv
// Shared types and codes for the FIFO free-list handle allocator.
// Holds request kinds, result status codes and the controller command bundle.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ffl_alloc_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned HandleW = 6;

  localparam logic [KindW-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KindW-1:0] KIND_TRY   = 2'd1;
  localparam logic [KindW-1:0] KIND_FREE  = 2'd2;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_NONE      = 2'd1;
  localparam logic [StatusW-1:0] ST_INVALID   = 2'd2;
  localparam logic [StatusW-1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

`default_nettype wire

### src/ffl_alloc_ctrl.sv
// Controller of the handle allocator: a two-state one-hot machine.
// Issues capture and execute commands to the datapath and raises the result strobe.
// Depends on ffl_alloc_pkg.
`default_nettype none

module ffl_alloc_ctrl
  import ffl_alloc_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start,
  output logic busy,
  output logic done_o,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_d, state_q;
  logic   done_d, done_q;

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign done_d = cmd_o.execute;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q == S_EXEC);
  assign done_o = done_q;

endmodule

`default_nettype wire

### src/ffl_alloc_dp.sv
// Datapath of the handle allocator: free queue memory, in-use bit memory,
// queue pointers, mint counter and result registers. Depends on ffl_alloc_pkg.
`default_nettype none

module ffl_alloc_dp
  import ffl_alloc_pkg::*;
#(
  parameter int unsigned POOL_SIZE = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cmd_t               cmd_i,
  input  wire  [KindW-1:0]   kind_i,
  input  wire  [HandleW-1:0] handle_in_i,
  output logic [HandleW-1:0] handle_out_o,
  output logic [StatusW-1:0] status_o
);

  localparam int unsigned IdxW = $clog2(POOL_SIZE);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned ExtW = IdxW + HandleW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(POOL_SIZE - 1);
  localparam logic [ExtW-1:0] PoolExt = ExtW'(POOL_SIZE);
  localparam logic [CntW-1:0] PoolCnt = CntW'(POOL_SIZE);

  logic [IdxW-1:0] fq_mem [POOL_SIZE];
  logic            iu_mem [POOL_SIZE];

  logic [KindW-1:0]   kind_q;
  logic [HandleW-1:0] hin_q;
  logic [IdxW-1:0]    fq_rd_q;
  logic               iu_rd_q;
  logic [HandleW-1:0] hout_d, hout_q;
  logic [StatusW-1:0] status_d, status_q;

  logic [IdxW-1:0] head_d, head_q, tail_d, tail_q;
  logic [CntW-1:0] count_d, count_q, minted_d, minted_q;

  logic [ExtW-1:0] hin_in_ext, hin_ext, minted_ext, grant_ext;
  logic [IdxW-1:0] hin_in_idx, hin_idx, grant_h, iu_wa;
  logic            is_alloc, is_try, is_free, have_freed, can_mint;
  logic            pop, mint, push, iu_we, iu_wd;

  assign hin_in_ext = {{IdxW{1'b0}}, handle_in_i};
  assign hin_in_idx = hin_in_ext[IdxW-1:0];
  assign hin_ext    = {{IdxW{1'b0}}, hin_q};
  assign hin_idx    = hin_ext[IdxW-1:0];
  assign minted_ext = {{(HandleW-1){1'b0}}, minted_q};

  assign is_alloc   = (kind_q == KIND_ALLOC);
  assign is_try     = (kind_q == KIND_TRY);
  assign is_free    = (kind_q == KIND_FREE);
  assign have_freed = (count_q != '0);
  assign can_mint   = (minted_q < PoolCnt);

  // A handle at or above the mint count has never been handed out, so its
  // in-use bit counts as clear whatever the memory holds.
  assign pop  = (is_alloc || is_try) && have_freed;
  assign mint = is_alloc && !have_freed && can_mint;
  assign push = is_free && (hin_ext < PoolExt) && iu_rd_q && (hin_ext < minted_ext)
                && (count_q < PoolCnt);

  assign grant_h   = pop ? fq_rd_q : minted_q[IdxW-1:0];
  assign grant_ext = {{HandleW{1'b0}}, grant_h};

  always_comb begin
    hout_d = '0;
    if (pop || mint) begin
      hout_d = grant_ext[HandleW-1:0];
    end
    if (pop || mint || push) begin
      status_d = ST_OK;
    end else if (is_try) begin
      status_d = ST_NONE;
    end else if (is_alloc) begin
      status_d = ST_EXHAUSTED;
    end else begin
      status_d = ST_INVALID;
    end
  end

  always_comb begin
    iu_we = cmd_i.execute && (pop || mint || push);
    iu_wa = (pop || mint) ? grant_h : hin_idx;
    iu_wd = pop || mint;
  end

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    minted_d = minted_q;
    if (cmd_i.execute) begin
      if (pop) begin
        head_d  = (head_q == LastIdx) ? '0 : head_q + 1'b1;
        count_d = count_q - 1'b1;
      end
      if (push) begin
        tail_d  = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
        count_d = count_q + 1'b1;
      end
      if (mint) begin
        minted_d = minted_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      minted_q <= '0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
      minted_q <= minted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      hin_q   <= handle_in_i;
      fq_rd_q <= fq_mem[head_q];
      iu_rd_q <= iu_mem[hin_in_idx];
    end
    if (cmd_i.execute && push) begin
      fq_mem[tail_q] <= hin_idx;
    end
    if (iu_we) begin
      iu_mem[iu_wa] <= iu_wd;
    end
    if (cmd_i.execute) begin
      hout_q   <= hout_d;
      status_q <= status_d;
    end
  end

  assign handle_out_o = hout_q;
  assign status_o     = status_q;

endmodule

`default_nettype wire

### src/fifo_free_list_handle_allocator.sv
// Top level of the FIFO free-list handle allocator.
// Joins ffl_alloc_ctrl and ffl_alloc_dp; depends on ffl_alloc_pkg.
//
//   Channel   Handshake            Payload
//   request   start, busy          kind_i, handle_in_i
//   result    done_o (strobe)      handle_out_o, status_o
//
// A request is taken when start is high and busy is low. The free-queue and
// in-use memories are read into registers at that edge; the following cycle
// decides and updates state, and the result strobe comes in the cycle after
// that. No new request is taken while busy is high, during that decision.
// No clearing pass after reset: in-use bits at or above the mint count read as clear.
// The receiver cannot stall; each result beat is shown for one cycle only.
`default_nettype none

module fifo_free_list_handle_allocator
  import ffl_alloc_pkg::*;
#(
  parameter int unsigned POOL_SIZE = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  wire  [KindW-1:0]   kind_i,
  input  wire  [HandleW-1:0] handle_in_i,
  output logic               done_o,
  output logic [HandleW-1:0] handle_out_o,
  output logic [StatusW-1:0] status_o
);

  cmd_t cmd;

  ffl_alloc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  ffl_alloc_dp #(
    .POOL_SIZE(POOL_SIZE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (kind_i),
    .handle_in_i  (handle_in_i),
    .handle_out_o (handle_out_o),
    .status_o     (status_o)
  );

  a_accept_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && cmd.execute))
    else $error("accepted request did not enter execution");

  a_exec_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (done_o && !busy))
    else $error("execution did not end in one result strobe");

  a_done_needs_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd.execute))
    else $error("result strobe without a preceding execution");

  a_no_grant_handle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (handle_out_o == '0))
    else $error("failed request returned a non-zero handle");

endmodule

`default_nettype wire
